>>> rtl/sexl_pkg.sv
package sexl_pkg;

  // Longest token, in characters
  localparam int unsigned MAX_TOKEN_LEN = 1024;
  localparam int unsigned CNT_W         = $clog2(MAX_TOKEN_LEN + 1);

  // Lexer modes
  typedef enum logic [3:0] {
    M_IDLE,
    M_COMMENT,
    M_STRING,
    M_ESC,
    M_HASH,
    M_HASHQ,
    M_NUMBER,
    M_DOT,
    M_SYMBOL
  } lex_mode_t;

  // Token kinds on the result channel
  typedef enum logic [3:0] {
    K_EOF     = 4'd0,
    K_ERROR   = 4'd1,
    K_OPEN    = 4'd2,
    K_CLOSE   = 4'd3,
    K_SYMBOL  = 4'd4,
    K_STRING  = 4'd5,
    K_INTEGER = 4'd6,
    K_REAL    = 4'd7,
    K_PATOPEN = 4'd8,
    K_DOT     = 4'd9,
    K_TRUE    = 4'd10,
    K_FALSE   = 4'd11
  } token_kind_t;

  // Result kinds
  localparam logic RK_CHAR  = 1'b0;
  localparam logic RK_TOKEN = 1'b1;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_RPAREN = 8'd41;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_POINT  = 8'd46;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_SEMI   = 8'd59;
  localparam logic [7:0] CH_QMARK  = 8'd63;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_F      = 8'd102;
  localparam logic [7:0] CH_N      = 8'd110;
  localparam logic [7:0] CH_T      = 8'd116;
  localparam logic [7:0] CH_HASH   = 8'd35;

  // One result item
  typedef struct packed {
    logic        kind;
    token_kind_t tkind;
    logic [7:0]  ch;
    logic        last;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return is_space(c) || (c == CH_QUOTE) || (c == CH_LPAREN) ||
           (c == CH_RPAREN) || (c == CH_SEMI);
  endfunction

endpackage

>>> rtl/sexpr_token_lexer_unit.sv
// Channel  Direction  Ports                       Contents
// in_      slave      tvalid tready tdata tuser   one text byte or end-of-input mark
// out_     master     tvalid tready tdata tuser   token character or completed token
//                     tlast                       marks last result of one input
//
// One input byte is taken per clock while the queue takes the results of the last one;
// each byte sits in an input register while the lexer logic forms up to two results
// into a two-entry output queue. Two results from one byte leave the queue one after
// the other, so the surplus builds up; a two-result byte waits until both fit.
// Either side may stall at any time; in_tready drops only when the queue has no
// room for the results of the byte in the input register.
// Synchronous active-low reset returns the lexer to idle between tokens.
module sexpr_token_lexer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_char
  input  logic        in_tuser,   // [0] in_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] token_kind, [11:4] out_char, [15:12] zero
  output logic        out_tuser,  // [0] out_kind
  output logic        out_tlast   // out_last
);

  localparam int unsigned CW = sexl_pkg::CNT_W;
  localparam logic [CW-1:0] MAXC = CW'(sexl_pkg::MAX_TOKEN_LEN);

  // Input register
  logic       s1_v_r, s1_v_nxt;
  logic [7:0] s1_ch_r;
  logic       s1_end_r;

  // Lexer state
  sexl_pkg::lex_mode_t mode_r, mode_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                sd_r, sd_nxt;
  logic                sn_r, sn_nxt;
  logic [1:0]          pc_r, pc_nxt;

  // Output queue
  sexl_pkg::result_t q_r [2];
  sexl_pkg::result_t q_nxt [2];
  logic [1:0]        qcnt_r, qcnt_nxt;

  // Results of the current byte
  sexl_pkg::result_t res [2];
  logic [1:0]        n;
  logic              fire, pop;
  logic [2:0]        room;

  // Lexer logic
  always_comb begin
    logic [7:0]            c;
    logic                  app_en;
    logic                  app_dot;
    logic [7:0]            app_ch;
    sexl_pkg::token_kind_t wkind;
    c        = s1_ch_r;
    app_en   = 1'b0;
    app_dot  = 1'b0;
    app_ch   = c;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    sd_nxt   = sd_r;
    sn_nxt   = sn_r;
    pc_nxt   = pc_r;
    n        = 2'd0;
    for (int i = 0; i < 2; i++) begin
      res[i] = '{kind: sexl_pkg::RK_CHAR, tkind: sexl_pkg::K_EOF, ch: 8'd0, last: 1'b0};
    end

    // kind of a bare word that ends now
    if (mode_r == sexl_pkg::M_NUMBER) begin
      if (sn_r || !sd_r || pc_r > 2'd1) wkind = sexl_pkg::K_SYMBOL;
      else if (pc_r == 2'd1)            wkind = sexl_pkg::K_REAL;
      else                              wkind = sexl_pkg::K_INTEGER;
    end else if (mode_r == sexl_pkg::M_DOT) begin
      wkind = sexl_pkg::K_DOT;
    end else begin
      wkind = sexl_pkg::K_SYMBOL;
    end

    if (s1_end_r) begin
      // end of input: close pending token, then eof
      case (mode_r)
        sexl_pkg::M_STRING, sexl_pkg::M_ESC, sexl_pkg::M_HASH, sexl_pkg::M_HASHQ: begin
          res[n[0]].kind  = sexl_pkg::RK_TOKEN;
          res[n[0]].tkind = sexl_pkg::K_ERROR;
          n = n + 2'd1;
        end
        sexl_pkg::M_NUMBER, sexl_pkg::M_SYMBOL, sexl_pkg::M_DOT: begin
          res[n[0]].kind  = sexl_pkg::RK_TOKEN;
          res[n[0]].tkind = wkind;
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      res[n[0]].kind  = sexl_pkg::RK_TOKEN;
      res[n[0]].tkind = sexl_pkg::K_EOF;
      n        = n + 2'd1;
      mode_nxt = sexl_pkg::M_IDLE;
      cnt_nxt  = '0;
      sd_nxt   = 1'b0;
      sn_nxt   = 1'b0;
      pc_nxt   = 2'd0;
    end else begin
      case (mode_r)
        sexl_pkg::M_COMMENT: begin
          if (c == sexl_pkg::CH_LF) mode_nxt = sexl_pkg::M_IDLE;
        end
        sexl_pkg::M_STRING: begin
          if (c == sexl_pkg::CH_QUOTE) begin
            res[0].kind  = sexl_pkg::RK_TOKEN;
            res[0].tkind = sexl_pkg::K_STRING;
            n        = 2'd1;
            mode_nxt = sexl_pkg::M_IDLE;
            cnt_nxt  = '0;
            sd_nxt   = 1'b0;
            sn_nxt   = 1'b0;
            pc_nxt   = 2'd0;
          end else if (c == sexl_pkg::CH_BSLASH) begin
            mode_nxt = sexl_pkg::M_ESC;
          end else begin
            app_en = 1'b1;
          end
        end
        sexl_pkg::M_ESC: begin
          mode_nxt = sexl_pkg::M_STRING;
          app_en   = 1'b1;
          if (c == sexl_pkg::CH_N)      app_ch = sexl_pkg::CH_LF;
          else if (c == sexl_pkg::CH_T) app_ch = sexl_pkg::CH_TAB;
        end
        sexl_pkg::M_HASH: begin
          mode_nxt = sexl_pkg::M_IDLE;
          if (c == sexl_pkg::CH_QMARK) begin
            mode_nxt = sexl_pkg::M_HASHQ;
          end else begin
            res[0].kind = sexl_pkg::RK_TOKEN;
            n = 2'd1;
            if (c == sexl_pkg::CH_T)      res[0].tkind = sexl_pkg::K_TRUE;
            else if (c == sexl_pkg::CH_F) res[0].tkind = sexl_pkg::K_FALSE;
            else                          res[0].tkind = sexl_pkg::K_ERROR;
          end
        end
        sexl_pkg::M_HASHQ: begin
          mode_nxt     = sexl_pkg::M_IDLE;
          res[0].kind  = sexl_pkg::RK_TOKEN;
          res[0].tkind = (c == sexl_pkg::CH_LPAREN) ? sexl_pkg::K_PATOPEN
                                                    : sexl_pkg::K_ERROR;
          n = 2'd1;
        end
        sexl_pkg::M_NUMBER, sexl_pkg::M_DOT, sexl_pkg::M_SYMBOL: begin
          if (sexl_pkg::is_delim(c)) begin
            // finish the word, then treat the delimiter as fresh input
            res[0].kind  = sexl_pkg::RK_TOKEN;
            res[0].tkind = wkind;
            n        = 2'd1;
            cnt_nxt  = '0;
            sd_nxt   = 1'b0;
            sn_nxt   = 1'b0;
            pc_nxt   = 2'd0;
            mode_nxt = sexl_pkg::M_IDLE;
            if (c == sexl_pkg::CH_SEMI) begin
              mode_nxt = sexl_pkg::M_COMMENT;
            end else if (c == sexl_pkg::CH_QUOTE) begin
              mode_nxt = sexl_pkg::M_STRING;
            end else if (c == sexl_pkg::CH_LPAREN || c == sexl_pkg::CH_RPAREN) begin
              res[1].kind  = sexl_pkg::RK_TOKEN;
              res[1].tkind = (c == sexl_pkg::CH_LPAREN) ? sexl_pkg::K_OPEN
                                                        : sexl_pkg::K_CLOSE;
              n = 2'd2;
            end
          end else if (mode_r == sexl_pkg::M_NUMBER) begin
            if (sexl_pkg::is_digit(c))         sd_nxt = 1'b1;
            else if (c == sexl_pkg::CH_POINT)  pc_nxt = (pc_r >= 2'd2) ? 2'd2 : pc_r + 2'd1;
            else                               sn_nxt = 1'b1;
            app_en = 1'b1;
          end else if (mode_r == sexl_pkg::M_DOT) begin
            mode_nxt = sexl_pkg::M_SYMBOL;
            app_en   = 1'b1;
            app_dot  = 1'b1;
          end else begin
            app_en = 1'b1;
          end
        end
        default: begin
          // between tokens
          cnt_nxt  = '0;
          sd_nxt   = 1'b0;
          sn_nxt   = 1'b0;
          pc_nxt   = 2'd0;
          mode_nxt = sexl_pkg::M_IDLE;
          if (sexl_pkg::is_space(c)) begin
            mode_nxt = sexl_pkg::M_IDLE;
          end else if (c == sexl_pkg::CH_SEMI) begin
            mode_nxt = sexl_pkg::M_COMMENT;
          end else if (c == sexl_pkg::CH_LPAREN || c == sexl_pkg::CH_RPAREN) begin
            res[0].kind  = sexl_pkg::RK_TOKEN;
            res[0].tkind = (c == sexl_pkg::CH_LPAREN) ? sexl_pkg::K_OPEN
                                                      : sexl_pkg::K_CLOSE;
            n = 2'd1;
          end else if (c == sexl_pkg::CH_QUOTE) begin
            mode_nxt = sexl_pkg::M_STRING;
          end else if (c == sexl_pkg::CH_HASH) begin
            mode_nxt = sexl_pkg::M_HASH;
          end else if (sexl_pkg::is_digit(c) || c == sexl_pkg::CH_MINUS) begin
            mode_nxt = sexl_pkg::M_NUMBER;
            sd_nxt   = sexl_pkg::is_digit(c);
            app_en   = 1'b1;
          end else if (c == sexl_pkg::CH_POINT) begin
            mode_nxt = sexl_pkg::M_DOT;
          end else begin
            mode_nxt = sexl_pkg::M_SYMBOL;
            app_en   = 1'b1;
          end
        end
      endcase

      // append one character, or a held '.' and then one, with overflow check
      if (app_en) begin
        if (app_dot) begin
          if (cnt_nxt >= MAXC) begin
            res[0].kind  = sexl_pkg::RK_TOKEN;
            res[0].tkind = sexl_pkg::K_ERROR;
            n        = 2'd1;
            mode_nxt = sexl_pkg::M_IDLE;
            cnt_nxt  = '0;
            sd_nxt   = 1'b0;
            sn_nxt   = 1'b0;
            pc_nxt   = 2'd0;
          end else begin
            res[0].ch = sexl_pkg::CH_POINT;
            cnt_nxt   = cnt_nxt + CW'(1);
            if (cnt_nxt >= MAXC) begin
              res[1].kind  = sexl_pkg::RK_TOKEN;
              res[1].tkind = sexl_pkg::K_ERROR;
              mode_nxt = sexl_pkg::M_IDLE;
              cnt_nxt  = '0;
              sd_nxt   = 1'b0;
              sn_nxt   = 1'b0;
              pc_nxt   = 2'd0;
            end else begin
              res[1].ch = app_ch;
              cnt_nxt   = cnt_nxt + CW'(1);
            end
            n = 2'd2;
          end
        end else begin
          if (cnt_nxt >= MAXC) begin
            res[0].kind  = sexl_pkg::RK_TOKEN;
            res[0].tkind = sexl_pkg::K_ERROR;
            mode_nxt = sexl_pkg::M_IDLE;
            cnt_nxt  = '0;
            sd_nxt   = 1'b0;
            sn_nxt   = 1'b0;
            pc_nxt   = 2'd0;
          end else begin
            res[0].ch = app_ch;
            cnt_nxt   = cnt_nxt + CW'(1);
          end
          n = 2'd1;
        end
      end
    end

    res[0].last = (n == 2'd1);
    res[1].last = (n == 2'd2);
  end

  // Handshake: the byte leaves the input register when its results fit
  assign pop       = out_tvalid && out_tready;
  assign room      = 3'd2 - {1'b0, qcnt_r} + {2'b00, pop};
  assign fire      = s1_v_r && ({1'b0, n} <= room);
  assign in_tready = !s1_v_r || fire;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_tready) s1_v_nxt = in_tvalid;
  end

  // Output queue update
  always_comb begin
    logic [1:0] base;
    logic [1:0] idx;
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = q_r[1];
    base     = qcnt_r - {1'b0, pop};
    for (int i = 0; i < 2; i++) begin
      idx = base + 2'(i);
      if (fire && (2'(i) < n)) q_nxt[idx[0]] = res[i];
    end
    qcnt_nxt = fire ? base + n : base;
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      mode_r <= sexl_pkg::M_IDLE;
      cnt_r  <= '0;
      sd_r   <= 1'b0;
      sn_r   <= 1'b0;
      pc_r   <= 2'd0;
      qcnt_r <= 2'd0;
    end else begin
      s1_v_r <= s1_v_nxt;
      qcnt_r <= qcnt_nxt;
      if (fire) begin
        mode_r <= mode_nxt;
        cnt_r  <= cnt_nxt;
        sd_r   <= sd_nxt;
        sn_r   <= sn_nxt;
        pc_r   <= pc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ch_r  <= in_tdata;
      s1_end_r <= in_tuser;
    end
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  // Result channel
  assign out_tvalid = (qcnt_r != 2'd0);
  assign out_tdata  = {4'd0, q_r[0].ch, q_r[0].tkind};
  assign out_tuser  = q_r[0].kind;
  assign out_tlast  = q_r[0].last;

endmodule

>>> dv/sexl_stream_checker.sv
module sexl_stream_checker
  import sexl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_char
  input  logic        in_tuser,   // [0] in_end
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [3:0] token_kind, [11:4] out_char, [15:12] zero
  input  logic        out_tuser,  // [0] out_kind
  input  logic        out_tlast,  // out_last
  output int          mismatches,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow lexer state
  lex_mode_t        mode;
  logic [CNT_W-1:0] tok_len;
  logic             digit_seen;
  logic             other_seen;
  logic [1:0]       points;

  // Results still owed by the block, oldest first
  result_t lexeme_q[$];
  result_t want;

  function automatic bit blank_ch(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit numeral_ch(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Bytes that end a bare word
  function automatic bit stop_ch(input logic [7:0] c);
    return blank_ch(c) || (c == CH_QUOTE) || (c == CH_LPAREN) ||
           (c == CH_RPAREN) || (c == CH_SEMI);
  endfunction

  task automatic clear_tok();
    tok_len    = '0;
    digit_seen = 1'b0;
    other_seen = 1'b0;
    points     = 2'd0;
  endtask

  task automatic emit_token(input token_kind_t k);
    result_t r;
    r.kind  = RK_TOKEN;
    r.tkind = k;
    r.ch    = 8'h00;
    r.last  = 1'b0;
    lexeme_q.push_back(r);
  endtask

  // Appends a token character, or flags an over-long token and drops to idle
  task automatic append_ch(input logic [7:0] c, output bit ok);
    result_t r;
    if (tok_len >= CNT_W'(MAX_TOKEN_LEN)) begin
      emit_token(K_ERROR);
      mode = M_IDLE;
      clear_tok();
      ok = 1'b0;
    end else begin
      tok_len = tok_len + 1'b1;
      r.kind  = RK_CHAR;
      r.tkind = K_EOF;
      r.ch    = c;
      r.last  = 1'b0;
      lexeme_q.push_back(r);
      ok = 1'b1;
    end
  endtask

  // Classifies the pending bare word
  task automatic close_word();
    token_kind_t k;
    if (mode == M_NUMBER) begin
      if (other_seen || !digit_seen || points > 2'd1) k = K_SYMBOL;
      else if (points == 2'd1)                        k = K_REAL;
      else                                            k = K_INTEGER;
    end else if (mode == M_DOT) begin
      k = K_DOT;
    end else begin
      k = K_SYMBOL;
    end
    emit_token(k);
    mode = M_IDLE;
    clear_tok();
  endtask

  // A byte seen between tokens
  task automatic open_token(input logic [7:0] c);
    bit ok;
    clear_tok();
    if (blank_ch(c)) begin
      mode = M_IDLE;
    end else if (c == CH_SEMI) begin
      mode = M_COMMENT;
    end else if (c == CH_LPAREN) begin
      mode = M_IDLE;
      emit_token(K_OPEN);
    end else if (c == CH_RPAREN) begin
      mode = M_IDLE;
      emit_token(K_CLOSE);
    end else if (c == CH_QUOTE) begin
      mode = M_STRING;
    end else if (c == CH_HASH) begin
      mode = M_HASH;
    end else if (numeral_ch(c) || c == CH_MINUS) begin
      mode       = M_NUMBER;
      digit_seen = numeral_ch(c);
      append_ch(c, ok);
    end else if (c == CH_POINT) begin
      mode = M_DOT;
    end else begin
      mode = M_SYMBOL;
      append_ch(c, ok);
    end
  endtask

  // Works out the results of one accepted byte or end mark
  task automatic lex_byte(input logic [7:0] c, input logic eoi);
    int prior_len;
    bit ok;
    prior_len = lexeme_q.size();
    if (eoi) begin
      case (mode)
        M_STRING, M_ESC, M_HASH, M_HASHQ: emit_token(K_ERROR);
        M_NUMBER, M_SYMBOL, M_DOT:        close_word();
        default: ;
      endcase
      emit_token(K_EOF);
      mode = M_IDLE;
      clear_tok();
    end else begin
      case (mode)
        M_COMMENT: begin
          if (c == CH_LF) mode = M_IDLE;
        end
        M_STRING: begin
          if (c == CH_QUOTE) begin
            emit_token(K_STRING);
            mode = M_IDLE;
            clear_tok();
          end else if (c == CH_BSLASH) begin
            mode = M_ESC;
          end else begin
            append_ch(c, ok);
          end
        end
        M_ESC: begin
          // back to the string first, so an overflow still lands in idle
          mode = M_STRING;
          append_ch((c == CH_N) ? CH_LF : (c == CH_T) ? CH_TAB : c, ok);
        end
        M_HASH: begin
          mode = M_IDLE;
          if (c == CH_T)          emit_token(K_TRUE);
          else if (c == CH_F)     emit_token(K_FALSE);
          else if (c == CH_QMARK) mode = M_HASHQ;
          else                    emit_token(K_ERROR);
        end
        M_HASHQ: begin
          mode = M_IDLE;
          emit_token((c == CH_LPAREN) ? K_PATOPEN : K_ERROR);
        end
        M_NUMBER, M_DOT, M_SYMBOL: begin
          if (stop_ch(c)) begin
            // the delimiter is handled again from idle
            close_word();
            open_token(c);
          end else if (mode == M_NUMBER) begin
            if (numeral_ch(c))       digit_seen = 1'b1;
            else if (c == CH_POINT)  points = (points == 2'd2) ? 2'd2 : points + 2'd1;
            else                     other_seen = 1'b1;
            append_ch(c, ok);
          end else if (mode == M_DOT) begin
            mode = M_SYMBOL;
            append_ch(CH_POINT, ok);
            if (ok) append_ch(c, ok);
          end else begin
            append_ch(c, ok);
          end
        end
        default: open_token(c);
      endcase
    end
    if (lexeme_q.size() > prior_len) lexeme_q[lexeme_q.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      mode = M_IDLE;
      clear_tok();
      lexeme_q.delete();
      mismatches = 0;
    end else begin
      if (in_tvalid && in_tready) lex_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (lexeme_q.size() == 0) begin
          $error("unexpected result: kind %0d tdata %h last %0d",
                 out_tuser, out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = lexeme_q.pop_front();
          check_field("out_kind", 8'(want.kind), 8'(out_tuser));
          check_field("token_kind", 8'(want.tkind), 8'(out_tdata[3:0]));
          check_field("out_char", want.ch, out_tdata[11:4]);
          check_field("tdata_pad", 8'h00, 8'(out_tdata[15:12]));
          check_field("out_last", 8'(want.last), 8'(out_tlast));
        end
      end
    end
    results_due = lexeme_q.size();
  end

endmodule

>>> dv/tb_sexpr_token_lexer_unit.sv
module tb_sexpr_token_lexer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sexl_pkg::*;

  localparam int         ITEMS     = 1700;
  localparam int         IDLE_MAX  = 2000;
  localparam int         LONG_HOLD = 400;
  localparam logic [7:0] CH_A      = 8'h61;

  // Opening text: brackets, booleans, pattern open, a real closed by ')',
  // a string with an escape and a high byte, a dot, a NUL symbol, a comment
  localparam logic [7:0] OPENING [23] = '{
    CH_LPAREN, CH_HASH, CH_T, CH_HASH, CH_F, CH_HASH, CH_QMARK, CH_LPAREN,
    CH_MINUS, CH_ZERO + 8'd1, CH_POINT, CH_ZERO + 8'd5, CH_RPAREN,
    CH_QUOTE, CH_BSLASH, CH_N, 8'hFF, CH_QUOTE,
    CH_POINT, CH_SPACE, 8'h00, CH_SEMI, CH_LF
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int mismatches;
  int results_due;
  int bytes_sent = 0;
  int quiet      = 0;
  bit tx_calm    = 1'b0;

  always #4 clk = ~clk;

  sexpr_token_lexer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sexl_stream_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  function automatic bit splits_word(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR) || (c == CH_QUOTE) ||
           (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_SEMI);
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (splits_word(c));
    return c;
  endfunction

  function automatic logic [7:0] blank_byte();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  // One transfer on the input channel, after a random gap
  task automatic put_byte(input logic [7:0] c, input logic eoi);
    int gap;
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= eoi;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic put_ch(input logic [7:0] c);
    put_byte(c, 1'b0);
  endtask

  task automatic put_eoi();
    put_byte(8'($urandom), 1'b1);
  endtask

  // Sender stops offering until every owed result has been taken
  task automatic hold_input_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // A token close to the length limit, either side of it
  task automatic put_long_token();
    int len;
    int kind;
    kind  = $urandom_range(0, 2);
    len   = $urandom_range(MAX_TOKEN_LEN - 2, MAX_TOKEN_LEN + 3);
    if (kind == 0) put_ch(CH_QUOTE);
    for (int i = 0; i < len; i++)
      put_ch((kind == 2) ? CH_ZERO + 8'($urandom_range(0, 9))
                         : CH_A + 8'($urandom_range(0, 25)));
    put_ch((kind == 0) ? CH_QUOTE : CH_SPACE);
    put_ch(CH_LF);
    put_eoi();
  endtask

  // A mostly well-formed piece of text, now and then broken or noisy
  task automatic put_phrase();
    int n;
    int r;
    logic [7:0] c;
    case ($urandom_range(0, 19))
      0, 1: begin
        n = $urandom_range(1, 3);
        repeat (n) put_ch(blank_byte());
      end
      2, 3: put_ch($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
      4, 5, 6, 17: begin
        // number-like word: sign, digits, points, the odd stray byte
        if ($urandom_range(0, 2) == 0) put_ch(CH_MINUS);
        else                           put_ch(CH_ZERO + 8'($urandom_range(0, 9)));
        n = $urandom_range(0, 6);
        repeat (n) begin
          r = $urandom_range(0, 9);
          if (r < 7)      put_ch(CH_ZERO + 8'($urandom_range(0, 9)));
          else if (r < 9) put_ch(CH_POINT);
          else            put_ch(word_byte());
        end
      end
      7, 8, 18: begin
        do c = word_byte();
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS || c == CH_POINT ||
               c == CH_HASH);
        put_ch(c);
        n = $urandom_range(0, 7);
        repeat (n) put_ch(word_byte());
      end
      9, 10, 19: begin
        put_ch(CH_QUOTE);
        n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0) begin
            put_ch(CH_BSLASH);
            case ($urandom_range(0, 4))
              0:       put_ch(CH_N);
              1:       put_ch(CH_T);
              2:       put_ch(CH_QUOTE);
              3:       put_ch(CH_BSLASH);
              default: put_ch(8'($urandom_range(0, 255)));
            endcase
          end else begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
            put_ch(c);
          end
        end
        put_ch(CH_QUOTE);
      end
      11: begin
        put_ch(CH_HASH);
        case ($urandom_range(0, 4))
          0: put_ch(CH_T);
          1: put_ch(CH_F);
          2: begin
            put_ch(CH_QMARK);
            put_ch($urandom_range(0, 3) ? CH_LPAREN : 8'($urandom_range(0, 255)));
          end
          default: put_ch(8'($urandom_range(0, 255)));
        endcase
      end
      12: begin
        put_ch(CH_POINT);
        n = $urandom_range(0, 3);
        repeat (n) put_ch(word_byte());
      end
      13: begin
        put_ch(CH_SEMI);
        n = $urandom_range(0, 6);
        repeat (n) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
          put_ch(c);
        end
        put_ch(CH_LF);
      end
      14: put_eoi();
      15: begin
        // text cut off by the end mark
        case ($urandom_range(0, 3))
          0: begin put_ch(CH_QUOTE); put_ch(word_byte()); end
          1: begin put_ch(CH_QUOTE); put_ch(CH_BSLASH); end
          2: put_ch(CH_HASH);
          default: begin put_ch(CH_HASH); put_ch(CH_QMARK); end
        endcase
        put_eoi();
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n) put_ch(8'($urandom_range(0, 255)));
      end
    endcase
    // usually a delimiter so the word gets classified on its own
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 3);
      put_ch((r == 0) ? CH_LPAREN : (r == 1) ? CH_RPAREN : blank_byte());
    end
  endtask

  // Result side: random stalls, calm stretches, two long hold-offs
  initial begin
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 12);
      if (taken == 400 || taken == 1200) stall = LONG_HOLD;
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= IDLE_MAX) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int k;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (OPENING[i]) put_ch(OPENING[i]);
    put_byte(8'hFF, 1'b1);
    hold_input_until_drained();

    k = 0;
    while (bytes_sent < ITEMS) begin
      if (k == 40) put_long_token();
      if (k == 100) hold_input_until_drained();
      put_phrase();
      k++;
    end
    put_eoi();

    // let the last results drain, then a short settle
    hold_input_until_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
